// ----- rtl/rcw_pkg.sv -----
// ---------------------------------------------------------------------------
// rcw_pkg: shared types and constants of the wall column setup block
// Field widths, divider lengths, pipeline depth, register map and the
// structures passed between the configuration, front, core and output parts.
// ---------------------------------------------------------------------------
`default_nettype none

package rcw_pkg;

  // Map size in bits of a cell coordinate.
  localparam int MAP_BITS = 8;
  localparam logic [7:0] CELL_MASK = (MAP_BITS >= 8) ? 8'hFF : 8'((1 << MAP_BITS) - 1);

  // Field widths.
  localparam int POS_W = 24;
  localparam int DIR_W = 18;
  localparam int NUM_W = POS_W + 2;   // signed distance to the hit grid line
  localparam int H_W   = 11;
  localparam int TL_W  = 4;
  localparam int TC_W  = 10;
  localparam int OUT_W = 28;

  localparam logic [OUT_W-1:0] OUT_SAT = {OUT_W{1'b1}};
  localparam logic [TL_W-1:0]  TEX_LOG2_MAX = 4'd10;

  // Line height division: screen_height * |dir| / |num|.
  localparam int LHN_W = H_W + DIR_W;   // dividend and quotient bits
  localparam int LHD_W = NUM_W - 1;     // divisor bits
  // Hit coordinate division: |num * dir_o| / |dir_h|.
  localparam int HN_W  = NUM_W + DIR_W - 2;
  localparam int HD_W  = DIR_W;
  // Texture step division: 2^(hl+16) / line height.
  localparam int TSN_W = 27;
  localparam int TSD_W = OUT_W;
  // Texture start position multiply, split in two partial products.
  localparam int V_W   = OUT_W - 1;
  localparam int V_LO  = 14;
  localparam int V_HI  = V_W - V_LO;

  // Core stage plan.
  localparam int ST_FIX  = LHN_W;               // line height, top and bottom
  localparam int ST_HIT  = HN_W;                // texture column
  localparam int ST_TS   = ST_FIX + TSN_W + 1;  // texture step and partial products
  localparam int ST_TPOS = ST_TS + 1;           // texture start sum
  localparam int NST     = ST_TPOS + 1;

  // Register map.
  localparam int PADDR_W = 4;
  localparam logic [1:0] REG_SCREEN_HEIGHT   = 2'd0;
  localparam logic [1:0] REG_TEX_WIDTH_LOG2  = 2'd1;
  localparam logic [1:0] REG_TEX_HEIGHT_LOG2 = 2'd2;

  // Face codes.
  localparam logic [1:0] FACE_WEST  = 2'd0;
  localparam logic [1:0] FACE_EAST  = 2'd1;
  localparam logic [1:0] FACE_NORTH = 2'd2;
  localparam logic [1:0] FACE_SOUTH = 2'd3;

  // Effective configuration, already clamped.
  typedef struct packed {
    logic [H_W-1:0]  h;
    logic [TL_W-1:0] wl;
    logic [TL_W-1:0] hl;
  } cfg_t;

  // First front stage.
  typedef struct packed {
    logic signed [NUM_W-1:0] num;
    logic signed [DIR_W-1:0] dir_h;
    logic signed [DIR_W-1:0] dir_o;
    logic [15:0]             pos_o;
    logic [1:0]              face;
    logic                    mirror;
  } fa_t;

  // Core pipeline word.
  typedef struct packed {
    logic [LHD_W-1:0] lh_rem;
    logic [LHN_W-1:0] lh_sh;
    logic [LHD_W-1:0] lh_den;
    logic             lh_sat;
    logic             lh_zero;
    logic [HD_W-1:0]  h_rem;
    logic [HN_W-1:0]  h_sh;
    logic [HD_W-1:0]  h_den;
    logic             h_neg;
    logic             h_dz;
    logic [15:0]      pos_o;
    logic [1:0]       face;
    logic             mirror;
    logic [TC_W-1:0]  tex_col;
    logic [H_W-1:0]   top;
    logic [H_W-1:0]   bottom;
    logic [V_W-1:0]   v;
    logic [TSD_W-1:0] ts_rem;
    logic [TSN_W-1:0] ts_sh;
    logic [TSD_W-1:0] ts_den;
    logic             ts_sat;
    logic [OUT_W-1:0] tstep;
    logic [V_LO+OUT_W-1:0] pp_lo;
    logic [V_HI+OUT_W-1:0] pp_hi;
    logic [OUT_W-1:0] tpos;
  } pl_t;

  // Result beat.
  typedef struct packed {
    logic [H_W-1:0]   wall_top;
    logic [H_W-1:0]   wall_bottom;
    logic [1:0]       face;
    logic [TC_W-1:0]  tex_col;
    logic [OUT_W-1:0] tex_pos_start;
    logic [OUT_W-1:0] tex_step;
  } res_t;

endpackage

`default_nettype wire

// ----- rtl/rcw_cfg.sv -----
// ---------------------------------------------------------------------------
// rcw_cfg: configuration registers
// APB-style register file holding screen height and texture sizes, and the
// clamped values the datapath works with.
// ---------------------------------------------------------------------------
`default_nettype none

module rcw_cfg import rcw_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output cfg_t               cfg_o
);

  logic [H_W-1:0]  screen_height_q;
  logic [TL_W-1:0] tex_width_log2_q;
  logic [TL_W-1:0] tex_height_log2_q;
  logic            wr;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;

  // Register writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      screen_height_q   <= 11'd480;
      tex_width_log2_q  <= 4'd6;
      tex_height_log2_q <= 4'd6;
    end else if (wr) begin
      unique case (paddr[3:2])
        REG_SCREEN_HEIGHT:   screen_height_q   <= pwdata[H_W-1:0];
        REG_TEX_WIDTH_LOG2:  tex_width_log2_q  <= pwdata[TL_W-1:0];
        REG_TEX_HEIGHT_LOG2: tex_height_log2_q <= pwdata[TL_W-1:0];
        default: ;
      endcase
    end
  end

  // Read back.
  always_comb begin
    unique case (paddr[3:2])
      REG_SCREEN_HEIGHT:   prdata = {21'd0, screen_height_q};
      REG_TEX_WIDTH_LOG2:  prdata = {28'd0, tex_width_log2_q};
      REG_TEX_HEIGHT_LOG2: prdata = {28'd0, tex_height_log2_q};
      default:             prdata = '0;
    endcase
  end

  // A zero height acts as one row; texture sizes stop at 1024.
  assign cfg_o.h  = (screen_height_q == '0) ? 11'd1 : screen_height_q;
  assign cfg_o.wl = (tex_width_log2_q > TEX_LOG2_MAX) ? TEX_LOG2_MAX : tex_width_log2_q;
  assign cfg_o.hl = (tex_height_log2_q > TEX_LOG2_MAX) ? TEX_LOG2_MAX : tex_height_log2_q;

endmodule

`default_nettype wire

// ----- rtl/rcw_front.sv -----
// ---------------------------------------------------------------------------
// rcw_front: hit geometry set-up
// Two stages: distance to the hit grid line and axis selection, then the
// products and magnitudes that feed the dividers in the core.
// ---------------------------------------------------------------------------
`default_nettype none

module rcw_front import rcw_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    en_i,
  input  cfg_t                    cfg_i,
  input  logic                    valid_i,
  input  logic [POS_W-1:0]        pos_x_i,
  input  logic [POS_W-1:0]        pos_y_i,
  input  logic signed [DIR_W-1:0] dir_x_i,
  input  logic signed [DIR_W-1:0] dir_y_i,
  input  logic [7:0]              cell_x_i,
  input  logic [7:0]              cell_y_i,
  input  logic signed [1:0]       step_x_i,
  input  logic signed [1:0]       step_y_i,
  input  logic                    hit_side_i,
  output logic                    valid_o,
  output pl_t                     pl_o
);

  logic va_q, vb_q;
  fa_t  fa_d, fa_q;
  pl_t  pb_d, pb_q;

  logic [7:0]                cell_sel;
  logic                      off;
  logic [8:0]                base;
  logic [POS_W-1:0]          pos_h;
  logic [NUM_W-1:0]          num_abs;
  logic [DIR_W-1:0]          dir_abs;
  logic signed [HN_W+1:0]    prod;
  logic [HN_W+1:0]           prod_abs;

  // Stage A: signed distance along the hit axis, face and mirroring.
  always_comb begin
    fa_d = '0;
    if (!hit_side_i) begin
      cell_sel = cell_x_i & CELL_MASK;
      off      = step_x_i[1];
      pos_h    = pos_x_i;
      fa_d.dir_h = dir_x_i;
      fa_d.dir_o = dir_y_i;
      fa_d.pos_o = pos_y_i[15:0];
      fa_d.face  = dir_x_i[DIR_W-1] ? FACE_WEST : FACE_EAST;
      fa_d.mirror = !dir_x_i[DIR_W-1] && (dir_x_i != '0);
    end else begin
      cell_sel = cell_y_i & CELL_MASK;
      off      = step_y_i[1];
      pos_h    = pos_y_i;
      fa_d.dir_h = dir_y_i;
      fa_d.dir_o = dir_x_i;
      fa_d.pos_o = pos_x_i[15:0];
      fa_d.face  = dir_y_i[DIR_W-1] ? FACE_NORTH : FACE_SOUTH;
      fa_d.mirror = dir_y_i[DIR_W-1];
    end
    base     = {1'b0, cell_sel} + {8'd0, off};
    fa_d.num = $signed({1'b0, base, 16'd0}) - $signed({2'b00, pos_h});
  end

  // Stage B: dividends, divisors and sign handling for both divisions.
  always_comb begin
    pb_d     = '0;
    num_abs  = fa_q.num[NUM_W-1] ? (~fa_q.num + 1'b1) : fa_q.num;
    dir_abs  = fa_q.dir_h[DIR_W-1] ? (~fa_q.dir_h + 1'b1) : fa_q.dir_h;
    prod     = (HN_W+2)'(fa_q.num) * (HN_W+2)'(fa_q.dir_o);
    prod_abs = prod[HN_W+1] ? (~prod + 1'b1) : prod;

    pb_d.lh_sh   = {{DIR_W{1'b0}}, cfg_i.h} * {{H_W{1'b0}}, dir_abs};
    pb_d.lh_den  = num_abs[LHD_W-1:0];
    pb_d.lh_sat  = (fa_q.num == '0) || (fa_q.dir_h == '0);
    pb_d.lh_zero = fa_q.num[NUM_W-1] != fa_q.dir_h[DIR_W-1];
    pb_d.h_sh    = prod_abs[HN_W-1:0];
    pb_d.h_den   = dir_abs;
    pb_d.h_neg   = prod[HN_W+1] != fa_q.dir_h[DIR_W-1];
    pb_d.h_dz    = fa_q.dir_h == '0;
    pb_d.pos_o   = fa_q.pos_o;
    pb_d.face    = fa_q.face;
    pb_d.mirror  = fa_q.mirror;
  end

  // Valid bits of both stages.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
    end else if (en_i) begin
      va_q <= valid_i;
      vb_q <= va_q;
    end
  end

  // Payload of both stages.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      fa_q <= fa_d;
      pb_q <= pb_d;
    end
  end

  assign valid_o = vb_q;
  assign pl_o    = pb_q;

endmodule

`default_nettype wire

// ----- rtl/rcw_core.sv -----
// ---------------------------------------------------------------------------
// rcw_core: divider pipeline
// One quotient bit per stage for line height, hit coordinate and texture
// step, with the span, texture column and start position worked out at
// fixed stages along the way.
// ---------------------------------------------------------------------------
`default_nettype none

module rcw_core import rcw_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic en_i,
  input  cfg_t cfg_i,
  input  logic valid_i,
  input  pl_t  pl_i,
  output logic valid_o,
  output res_t res_o
);

  logic [NST-1:0] v_q;
  pl_t            src [NST];
  pl_t            p_q [NST];

  assign src[0] = pl_i;
  for (genvar j = 1; j < NST; j++) begin : g_src
    assign src[j] = p_q[j-1];
  end

  for (genvar k = 0; k < NST; k++) begin : g_stage
    pl_t                  n;
    logic [LHD_W:0]       lt;
    logic [HD_W:0]        ht;
    logic [TSD_W:0]       tt;
    logic [OUT_W-1:0]     lh;
    logic [V_W-1:0]       lh2;
    logic [V_W-1:0]       hh;
    logic                 cl;
    logic [15:0]          qs;
    logic [15:0]          qf;
    logic [15:0]          hit;
    logic [TC_W-1:0]      col;
    logic [TC_W-1:0]      wmask;
    logic [OUT_W-1:0]     ts;
    logic [V_LO+OUT_W+V_HI:0] sum;

    always_comb begin
      n     = src[k];
      lt    = '0;
      ht    = '0;
      tt    = '0;
      lh    = '0;
      lh2   = '0;
      hh    = '0;
      cl    = 1'b0;
      qs    = '0;
      qf    = '0;
      hit   = '0;
      col   = '0;
      wmask = '0;
      ts    = '0;
      sum   = '0;

      // Hit coordinate division step.
      if (k < HN_W) begin
        ht = {src[k].h_rem, src[k].h_sh[HN_W-1]};
        if (ht >= {1'b0, src[k].h_den}) begin
          n.h_rem = HD_W'(ht - {1'b0, src[k].h_den});
          n.h_sh  = {src[k].h_sh[HN_W-2:0], 1'b1};
        end else begin
          n.h_rem = ht[HD_W-1:0];
          n.h_sh  = {src[k].h_sh[HN_W-2:0], 1'b0};
        end
      end

      // Line height division step.
      if (k < LHN_W) begin
        lt = {src[k].lh_rem, src[k].lh_sh[LHN_W-1]};
        if (lt >= {1'b0, src[k].lh_den}) begin
          n.lh_rem = LHD_W'(lt - {1'b0, src[k].lh_den});
          n.lh_sh  = {src[k].lh_sh[LHN_W-2:0], 1'b1};
        end else begin
          n.lh_rem = lt[LHD_W-1:0];
          n.lh_sh  = {src[k].lh_sh[LHN_W-2:0], 1'b0};
        end
      end

      // Line height with saturation, wall span and texture step set-up.
      if (k == ST_FIX) begin
        if (src[k].lh_sat) begin
          lh = OUT_SAT;
        end else if (src[k].lh_zero) begin
          lh = '0;
        end else if (src[k].lh_sh > LHN_W'(OUT_SAT)) begin
          lh = OUT_SAT;
        end else begin
          lh = src[k].lh_sh[OUT_W-1:0];
        end
        lh2 = lh[OUT_W-1:1];
        hh  = V_W'(cfg_i.h[H_W-1:1]);
        cl  = hh <= lh2;
        if (cl) begin
          n.top    = '0;
          n.bottom = cfg_i.h - 11'd1;
          n.v      = lh2 - hh;
        end else begin
          n.top    = H_W'(hh - lh2);
          n.bottom = cfg_i.h - H_W'(hh - lh2);
          n.v      = '0;
        end
        n.ts_rem = '0;
        n.ts_sh  = TSN_W'(1) << (5'(cfg_i.hl) + 5'd16);
        n.ts_den = lh;
        n.ts_sat = lh == '0;
      end

      // Texture step division step.
      if (k > ST_FIX && k < ST_TS) begin
        tt = {src[k].ts_rem, src[k].ts_sh[TSN_W-1]};
        if (tt >= {1'b0, src[k].ts_den}) begin
          n.ts_rem = TSD_W'(tt - {1'b0, src[k].ts_den});
          n.ts_sh  = {src[k].ts_sh[TSN_W-2:0], 1'b1};
        end else begin
          n.ts_rem = tt[TSD_W-1:0];
          n.ts_sh  = {src[k].ts_sh[TSN_W-2:0], 1'b0};
        end
      end

      // Floor of the hit quotient, fraction and texture column.
      if (k == ST_HIT) begin
        qs = src[k].h_sh[15:0] + {15'd0, src[k].h_rem != '0};
        if (src[k].h_dz) begin
          qf = '0;
        end else if (src[k].h_neg) begin
          qf = ~qs + 16'd1;
        end else begin
          qf = src[k].h_sh[15:0];
        end
        hit   = src[k].pos_o + qf;
        col   = TC_W'(hit >> (5'd16 - 5'(cfg_i.wl)));
        wmask = TC_W'((11'd1 << cfg_i.wl) - 11'd1);
        n.tex_col = src[k].mirror ? (wmask - col) : col;
      end

      // Texture step and the two partial products of the start position.
      if (k == ST_TS) begin
        ts      = src[k].ts_sat ? OUT_SAT : {1'b0, src[k].ts_sh};
        n.tstep = ts;
        n.pp_lo = {{OUT_W{1'b0}}, src[k].v[V_LO-1:0]} * {{V_LO{1'b0}}, ts};
        n.pp_hi = {{OUT_W{1'b0}}, src[k].v[V_W-1:V_LO]} * {{V_HI{1'b0}}, ts};
      end

      // Start position sum with saturation.
      if (k == ST_TPOS) begin
        sum = {1'b0, src[k].pp_hi, {V_LO{1'b0}}} + {{(V_HI+1){1'b0}}, src[k].pp_lo};
        n.tpos = (sum > {{(V_LO+V_HI+1){1'b0}}, OUT_SAT}) ? OUT_SAT : sum[OUT_W-1:0];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        p_q[k] <= n;
      end
    end
  end

  // Valid bits travel with the stages.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[NST-2:0], valid_i};
    end
  end

  assign valid_o             = v_q[NST-1];
  assign res_o.wall_top      = p_q[NST-1].top;
  assign res_o.wall_bottom   = p_q[NST-1].bottom;
  assign res_o.face          = p_q[NST-1].face;
  assign res_o.tex_col       = p_q[NST-1].tex_col;
  assign res_o.tex_pos_start = p_q[NST-1].tpos;
  assign res_o.tex_step      = p_q[NST-1].tstep;

endmodule

`default_nettype wire

// ----- rtl/rcw_out.sv -----
// ---------------------------------------------------------------------------
// rcw_out: output register with skid stage
// Holds the result beat for the consumer and catches one more beat when the
// consumer stalls, so the pipeline stops only when both are full.
// ---------------------------------------------------------------------------
`default_nettype none

module rcw_out import rcw_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic valid_i,
  input  res_t res_i,
  output logic en_o,
  output logic valid_o,
  input  logic stall_i,
  output res_t res_o
);

  logic out_valid_q, skid_valid_q;
  res_t out_q, skid_q;

  assign en_o    = !skid_valid_q;
  assign valid_o = out_valid_q;
  assign res_o   = out_q;

  // Occupancy of the output and skid registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (!stall_i) begin
        skid_valid_q <= 1'b0;
      end
    end else if (!out_valid_q || !stall_i) begin
      out_valid_q <= valid_i;
    end else if (valid_i) begin
      skid_valid_q <= 1'b1;
    end
  end

  // Beat data.
  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (!stall_i) begin
        out_q <= skid_q;
      end
    end else if (!out_valid_q || !stall_i) begin
      out_q <= res_i;
    end else begin
      skid_q <= res_i;
    end
  end

  // The skid register is only ever filled behind a held output beat.
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid register holds a beat while the output is empty");

  a_skid_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skid_valid_q) |-> $past(out_valid_q && stall_i && valid_i))
    else $error("skid register filled without a stalled output beat");

  a_out_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !stall_i && !skid_valid_q && !valid_i) |=> !out_valid_q)
    else $error("output beat repeated after it was taken");

endmodule

`default_nettype wire

// ----- rtl/raycast_wall_column_setup.sv -----
// Throughput: one column per cycle while the skid stage is empty; the divider stages run one quotient bit each.
// The core holds 59 stages, behind two front stages and one output register.
// A stalled output fills a one-beat skid stage before the input is stalled.
// Reset clears all valid bits and loads screen height 480 and both texture sizes 64.
// ---------------------------------------------------------------------------
// raycast_wall_column_setup: wall column set-up for a textured raycaster
// Turns the wall hit of one screen column into the wall span, face, texture
// column, texture step and texture start position.
// ---------------------------------------------------------------------------
`default_nettype none

module raycast_wall_column_setup import rcw_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  // Configuration port.
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [PADDR_W-1:0]      paddr,
  input  logic [31:0]             pwdata,
  output logic [31:0]             prdata,
  output logic                    pready,
  // Input channel.
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [POS_W-1:0]        pos_x_i,
  input  logic [POS_W-1:0]        pos_y_i,
  input  logic signed [DIR_W-1:0] dir_x_i,
  input  logic signed [DIR_W-1:0] dir_y_i,
  input  logic [7:0]              cell_x_i,
  input  logic [7:0]              cell_y_i,
  input  logic signed [1:0]       step_x_i,
  input  logic signed [1:0]       step_y_i,
  input  logic                    hit_side_i,
  // Output channel.
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic [H_W-1:0]          wall_top_o,
  output logic [H_W-1:0]          wall_bottom_o,
  output logic [1:0]              face_o,
  output logic [TC_W-1:0]         tex_col_o,
  output logic [OUT_W-1:0]        tex_pos_start_o,
  output logic [OUT_W-1:0]        tex_step_o
);

  cfg_t cfg;
  logic en;
  logic front_valid, core_valid;
  pl_t  front_pl;
  res_t core_res, out_res;

  assign in_stall_o = !en;

  rcw_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  rcw_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .cfg_i      (cfg),
    .valid_i    (in_valid_i),
    .pos_x_i    (pos_x_i),
    .pos_y_i    (pos_y_i),
    .dir_x_i    (dir_x_i),
    .dir_y_i    (dir_y_i),
    .cell_x_i   (cell_x_i),
    .cell_y_i   (cell_y_i),
    .step_x_i   (step_x_i),
    .step_y_i   (step_y_i),
    .hit_side_i (hit_side_i),
    .valid_o    (front_valid),
    .pl_o       (front_pl)
  );

  rcw_core u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .cfg_i   (cfg),
    .valid_i (front_valid),
    .pl_i    (front_pl),
    .valid_o (core_valid),
    .res_o   (core_res)
  );

  rcw_out u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (core_valid),
    .res_i   (core_res),
    .en_o    (en),
    .valid_o (out_valid_o),
    .stall_i (out_stall_i),
    .res_o   (out_res)
  );

  assign wall_top_o      = out_res.wall_top;
  assign wall_bottom_o   = out_res.wall_bottom;
  assign face_o          = out_res.face;
  assign tex_col_o       = out_res.tex_col;
  assign tex_pos_start_o = out_res.tex_pos_start;
  assign tex_step_o      = out_res.tex_step;

endmodule

`default_nettype wire

// ----- tb/tb_top.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_top: self-checking bench for the raycaster wall column set-up block
// Drives wall hits through the input channel, predicts every result beat
// with an independent integer model and compares each field on the output,
// under several idling phases and register settings.
// ---------------------------------------------------------------------------
`default_nettype none

module tb_top import rcw_pkg::*; ();

  localparam int LATENCY = 62;
  localparam longint MAX_CYCLES = 400000;

  // Expected column result.
  typedef struct {
    logic [H_W-1:0]   top;
    logic [H_W-1:0]   bottom;
    logic [1:0]       face;
    logic [TC_W-1:0]  col;
    logic [OUT_W-1:0] tpos;
    logic [OUT_W-1:0] tstep;
  } column_t;

  // Wall hit of one column.
  typedef struct {
    logic [POS_W-1:0]        px, py;
    logic signed [DIR_W-1:0] dx, dy;
    logic [7:0]              cx, cy;
    logic signed [1:0]       sx, sy;
    logic                    side;
  } hit_t;

  // Column predictor and store of pending expectations.
  class column_scoreboard;
    logic [10:0] rows = 11'd480;
    logic [3:0]  tw = 4'd6;
    logic [3:0]  th = 4'd6;
    column_t pending[$];
    int errors = 0;

    function longint fdiv(longint a, longint b);
      longint q;
      q = a / b;
      if ((a % b) != 0 && ((a < 0) != (b < 0))) q--;
      return q;
    endfunction

    // Notes an accepted hit and predicts its column.
    function void note_hit(hit_t x);
      column_t c;
      longint h, wl, hl, num, dh, dox, po, lh, top, bot, hitc, col, ts, v, tp;
      h = (rows == 0) ? 1 : rows;
      wl = (tw > 10) ? 10 : tw;
      hl = (th > 10) ? 10 : th;
      if (!x.side) begin
        num = ((longint'(x.cx) + (x.sx < 0 ? 1 : 0)) << 16) - longint'(x.px);
        dh = x.dx; dox = x.dy; po = x.py;
      end else begin
        num = ((longint'(x.cy) + (x.sy < 0 ? 1 : 0)) << 16) - longint'(x.py);
        dh = x.dy; dox = x.dx; po = x.px;
      end
      if (num == 0 || dh == 0) lh = OUT_SAT;
      else if ((num < 0) != (dh < 0)) lh = 0;
      else begin
        lh = (h * (dh < 0 ? -dh : dh)) / (num < 0 ? -num : num);
        if (lh > OUT_SAT) lh = OUT_SAT;
      end
      top = h / 2 - lh / 2;
      if (top < 0) top = 0;
      bot = h - top;
      if (bot > h - 1) bot = h - 1;
      if (!x.side) c.face = (x.dx < 0) ? FACE_WEST : FACE_EAST;
      else c.face = (x.dy < 0) ? FACE_NORTH : FACE_SOUTH;
      hitc = po;
      if (dh != 0) hitc += fdiv(num * dox, dh);
      col = (hitc & 16'hFFFF) >> (16 - wl);
      if ((!x.side && x.dx > 0) || (x.side && x.dy < 0)) col = (1 << wl) - col - 1;
      if (lh == 0) ts = OUT_SAT;
      else begin
        ts = (longint'(1) << (hl + 16)) / lh;
        if (ts > OUT_SAT) ts = OUT_SAT;
      end
      v = top - h / 2 + lh / 2;
      tp = (v > 0) ? v * ts : 0;
      if (tp > OUT_SAT) tp = OUT_SAT;
      c.top = top[10:0];
      c.bottom = bot[10:0];
      c.col = col[9:0];
      c.tpos = tp[27:0];
      c.tstep = ts[27:0];
      pending.push_back(c);
    endfunction

    function void report(string what, longint got, longint want);
      errors++;
      if (errors <= 40) $display("MISMATCH %s: got %0d, expected %0d", what, got, want);
    endfunction

    // Compares one result beat with the oldest expectation.
    function void check_column(column_t r);
      column_t e;
      if (pending.size() == 0) begin
        report("unexpected result beat", 1, 0);
        return;
      end
      e = pending.pop_front();
      if (r.top !== e.top) report("wall_top", r.top, e.top);
      if (r.bottom !== e.bottom) report("wall_bottom", r.bottom, e.bottom);
      if (r.face !== e.face) report("face", r.face, e.face);
      if (r.col !== e.col) report("tex_col", r.col, e.col);
      if (r.tpos !== e.tpos) report("tex_pos_start", r.tpos, e.tpos);
      if (r.tstep !== e.tstep) report("tex_step", r.tstep, e.tstep);
    endfunction
  endclass

  logic clk, rst_n;
  logic psel, penable, pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [31:0] pwdata, prdata;
  logic pready;
  logic in_valid, in_stall, out_valid, out_stall;
  hit_t cur;
  logic [H_W-1:0] wall_top, wall_bottom;
  logic [1:0] face;
  logic [TC_W-1:0] tex_col;
  logic [OUT_W-1:0] tex_pos_start, tex_step;

  column_scoreboard sb;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit hold_off = 0;
  longint cycles = 0;

  raycast_wall_column_setup u_dut (
    .clk_i(clk), .rst_ni(rst_n),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .pos_x_i(cur.px), .pos_y_i(cur.py), .dir_x_i(cur.dx), .dir_y_i(cur.dy),
    .cell_x_i(cur.cx), .cell_y_i(cur.cy), .step_x_i(cur.sx), .step_y_i(cur.sy),
    .hit_side_i(cur.side),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .wall_top_o(wall_top), .wall_bottom_o(wall_bottom), .face_o(face),
    .tex_col_o(tex_col), .tex_pos_start_o(tex_pos_start), .tex_step_o(tex_step)
  );

  // Clock and timeout.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > MAX_CYCLES) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Receiver: random stalls plus a long hold-off when asked.
  always @(posedge clk) begin
    if (!rst_n) out_stall <= 1'b0;
    else out_stall <= hold_off || ($urandom_range(99) < recv_stall_pct);
  end

  // Result monitor.
  always @(posedge clk) begin
    column_t r;
    if (rst_n && out_valid && !out_stall) begin
      r.top = wall_top; r.bottom = wall_bottom; r.face = face;
      r.col = tex_col; r.tpos = tex_pos_start; r.tstep = tex_step;
      sb.check_column(r);
    end
  end

  // One register write: setup then access cycle.
  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    @(posedge clk);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= PADDR_W'(idx) << 2; pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      REG_SCREEN_HEIGHT:   sb.rows = val[10:0];
      REG_TEX_WIDTH_LOG2:  sb.tw = val[3:0];
      default:             sb.th = val[3:0];
    endcase
  endtask

  // Offers one hit beat and waits until it is taken.
  task automatic send_hit(input hit_t x);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    cur <= x;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_hit(x);
  endtask

  task automatic drain();
    while (sb.pending.size() != 0) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    repeat (LATENCY + 10) @(posedge clk);
  endtask

  // Well-formed hits: the wall lies ahead along the ray most of the time.
  function automatic hit_t random_hit();
    hit_t x;
    x.px = POS_W'($urandom); x.py = POS_W'($urandom);
    x.dx = DIR_W'($urandom); x.dy = DIR_W'($urandom);
    x.cx = 8'($urandom); x.cy = 8'($urandom);
    x.sx = 2'($urandom); x.sy = 2'($urandom);
    x.side = 1'($urandom);
    if ($urandom_range(3) != 0) begin
      x.sx = x.dx < 0 ? -2'sd1 : 2'sd1;
      x.sy = x.dy < 0 ? -2'sd1 : 2'sd1;
      x.cx = x.px[23:16] + (x.sx < 0 ? -8'($urandom_range(3)) : 8'($urandom_range(3)));
      x.cy = x.py[23:16] + (x.sy < 0 ? -8'($urandom_range(3)) : 8'($urandom_range(3)));
      if ($urandom_range(7) == 0) begin
        x.dx = $signed(18'($urandom_range(4))) - 18'sd2;
      end
    end
    return x;
  endfunction

  function automatic hit_t directed_hit(int k);
    hit_t x;
    x = random_hit();
    case (k % 12)
      0: begin x.px = '0; x.py = '0; x.dx = 18'sh1FFFF; x.dy = -18'sh20000; end
      1: begin x.px = '1; x.py = '1; x.dx = -18'sh20000; x.dy = 18'sh1FFFF; end
      2: begin x.dx = '0; x.side = 1'b0; end
      3: begin x.dy = '0; x.side = 1'b1; end
      4: begin x.side = 1'b0; x.sx = 2'sd1; x.px = {x.cx, 16'h0}; end
      5: begin x.side = 1'b1; x.sy = -2'sd1; x.py = {x.cy + 8'd1, 16'h0}; end
      6: begin x.side = 1'b0; x.sx = 2'sd0; x.cx = 8'hFF; x.dx = 18'sh10000; end
      7: begin x.side = 1'b1; x.sy = -2'sd2; x.cy = 8'h00; x.dy = -18'sh10000; end
      8: begin x.side = 1'b0; x.px = 24'h800000; x.cx = 8'h10; x.sx = 2'sd1;
               x.dx = 18'sh00100; end
      9: begin x.side = 1'b1; x.cy = 8'hFF; x.py = 24'hFFFFFF; x.sy = 2'sd1;
               x.dy = -18'sh00001; end
      10: begin x.cx = '1; x.cy = '1; x.sx = -2'sd1; x.sy = -2'sd1; end
      default: begin x.cx = '0; x.cy = '0; x.dx = 18'sh1; x.dy = -18'sh1; end
    endcase
    return x;
  endfunction

  // Stimulus sequence.
  initial begin
    int phase;
    sb = new();
    rst_n = 1'b0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    in_valid = 1'b0;
    out_stall = 1'b0;
    cur = '{default: '0};
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed hits at reset settings.
    for (int k = 0; k < 24; k++) send_hit(directed_hit(k));
    drain();

    for (phase = 0; phase < 8; phase++) begin
      case (phase)
        0: begin write_reg(REG_SCREEN_HEIGHT, 1); write_reg(REG_TEX_WIDTH_LOG2, 0);
                 write_reg(REG_TEX_HEIGHT_LOG2, 0); end
        1: begin write_reg(REG_SCREEN_HEIGHT, 2047); write_reg(REG_TEX_WIDTH_LOG2, 10);
                 write_reg(REG_TEX_HEIGHT_LOG2, 10); end
        2: begin write_reg(REG_SCREEN_HEIGHT, 0); write_reg(REG_TEX_WIDTH_LOG2, 15);
                 write_reg(REG_TEX_HEIGHT_LOG2, 12); end
        default: begin
          write_reg(REG_SCREEN_HEIGHT, $urandom_range(2047));
          write_reg(REG_TEX_WIDTH_LOG2, $urandom_range(15));
          write_reg(REG_TEX_HEIGHT_LOG2, $urandom_range(15));
        end
      endcase
      case (phase % 4)
        0: begin send_idle_pct = 0; recv_stall_pct = 0; end
        1: begin send_idle_pct = 75; recv_stall_pct = 0; end
        2: begin send_idle_pct = 0; recv_stall_pct = 75; end
        default: begin send_idle_pct = 6; recv_stall_pct = 6; end
      endcase
      if (phase == 4) begin
        // Long receiver hold-off while the sender keeps offering beats.
        fork
          begin
            hold_off = 1'b1;
            repeat (300) @(posedge clk);
            hold_off = 1'b0;
          end
        join_none
      end
      for (int n = 0; n < 220; n++) begin
        send_hit(random_hit());
        if (n == 110 && phase == 5) drain();
      end
      drain();
    end

    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
